@@ hw/rtl/spc_pkg.sv @@
`default_nettype none

package spc_pkg;

	// Loop timing: integrator step is err * 2^(16 - LOOP_TIME_SHIFT)
	localparam int LOOP_TIME_SHIFT = 6;
	localparam int INTEG_SHIFT     = 16 - LOOP_TIME_SHIFT;

	// Field widths
	localparam int ANGLE_W = 15;
	localparam int SPEED_W = 16;
	localparam int DUTY_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 31;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEER_PROP_GAIN   = 3'd0,
		REG_STEER_OUTPUT_GAIN = 3'd1,
		REG_STEER_TIME_CONST  = 3'd2,
		REG_STEER_INTEG_LIMIT = 3'd3,
		REG_DRIVE_OUTPUT_GAIN = 3'd4,
		REG_DRIVE_TIME_CONST  = 3'd5,
		REG_DRIVE_INTEG_LIMIT = 3'd6,
		REG_TURN_FEEDFORWARD  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] steer_prop_gain;
		logic [GAIN_W-1:0] steer_output_gain;
		logic [GAIN_W-1:0] steer_time_const;
		logic [LIM_W-1:0]  steer_integ_limit;
		logic [GAIN_W-1:0] drive_output_gain;
		logic [GAIN_W-1:0] drive_time_const;
		logic [LIM_W-1:0]  drive_integ_limit;
		logic [GAIN_W-1:0] turn_feedforward;
	} cfg_t;

	// Angle arithmetic, 1/64 degree
	localparam int ANG_W = ANGLE_W + 2;
	localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(11520);
	localparam logic signed [ANG_W-1:0] ANG_FULL    = ANG_W'(23040);
	localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(5760);

	// Shared multiplier
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Datapath widths
	localparam int RATE_W   = 23;
	localparam int FF_W     = 30;
	localparam int ERR_W    = MUL_A_W;
	localparam int INTEG_W  = 32;
	localparam int ACC_W    = ERR_W + INTEG_SHIFT + 1;
	localparam int SUMF_W   = MUL_P_W + 9;
	localparam int SUM_BITS = 24;
	localparam int SUM_W    = SUM_BITS + 2;
	localparam int DUTY_PRE_W = MUL_P_W - 9 + 1;

	localparam logic signed [SUMF_W-1:0] SUM_MAX = SUMF_W'(1) <<< SUM_BITS;
	localparam logic signed [DUTY_PRE_W-1:0] DUTY_MAX = DUTY_PRE_W'(32767);
	localparam logic signed [DUTY_PRE_W-1:0] DUTY_MIN = -DUTY_PRE_W'(32768);

endpackage

`default_nettype wire

@@ hw/rtl/spc_if.sv @@
`default_nettype none

interface spc_tick_if import spc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] target_angle;
	logic signed [SPEED_W-1:0] target_speed;
	logic signed [ANGLE_W-1:0] measured_angle;
	logic signed [SPEED_W-1:0] measured_steer_rate;
	logic signed [SPEED_W-1:0] measured_speed;

	modport source (
		output valid, target_angle, target_speed, measured_angle,
			measured_steer_rate, measured_speed,
		input  ready
	);
	modport sink (
		input  valid, target_angle, target_speed, measured_angle,
			measured_steer_rate, measured_speed,
		output ready
	);
endinterface

interface spc_duty_if import spc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DUTY_W-1:0] steer_command;
	logic signed [DUTY_W-1:0] drive_command;
	logic                     reversed;

	modport source (
		output valid, steer_command, drive_command, reversed,
		input  ready
	);
	modport sink (
		input  valid, steer_command, drive_command, reversed,
		output ready
	);
endinterface

interface spc_cfg_if import spc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

@@ hw/rtl/spc_cfg_regs.sv @@
`default_nettype none

module spc_cfg_regs import spc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	spc_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_STEER_PROP_GAIN:   regs_q.steer_prop_gain   <= cfg.data[GAIN_W-1:0];
				REG_STEER_OUTPUT_GAIN: regs_q.steer_output_gain <= cfg.data[GAIN_W-1:0];
				REG_STEER_TIME_CONST:  regs_q.steer_time_const  <= cfg.data[GAIN_W-1:0];
				REG_STEER_INTEG_LIMIT: regs_q.steer_integ_limit <= cfg.data[LIM_W-1:0];
				REG_DRIVE_OUTPUT_GAIN: regs_q.drive_output_gain <= cfg.data[GAIN_W-1:0];
				REG_DRIVE_TIME_CONST:  regs_q.drive_time_const  <= cfg.data[GAIN_W-1:0];
				REG_DRIVE_INTEG_LIMIT: regs_q.drive_integ_limit <= cfg.data[LIM_W-1:0];
				REG_TURN_FEEDFORWARD:  regs_q.turn_feedforward  <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/spc_mul.sv @@
`default_nettype none

module spc_mul import spc_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	logic signed [MUL_P_W-1:0] p_q;

	assign p = p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/swerve_module_pi_control_unit.sv @@
`default_nettype none

// Swerve module steer/drive controller. One beat on tick runs one control step:
// angle error with reverse handling and wrap, proportional steer rate command,
// then steer and drive PI velocity loops with clamped integrators, giving one
// beat on duty (saturated Q1.15 steer and drive duty plus the reverse flag).
// A single 32x17 multiplier, shared by both loops under a step sequencer, does
// all products. How long an item keeps the block busy after its accept depends
// on how many 360 degree wrap steps the angle error needs and on whether the
// reverse flag toggles, and it stays in ST_DONE while the previous result still
// waits in the duty register. tick.ready is high only between items. Registers
// on cfg are taken every cycle and must be written while the block is idle.
module swerve_module_pi_control_unit import spc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	spc_tick_if.sink    tick,
	spc_duty_if.source  duty,
	spc_cfg_if.sink     cfg
);

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_WRAP1    = 13'b0000000000010,
		ST_FLIP     = 13'b0000000000100,
		ST_WRAP2    = 13'b0000000001000,
		ST_RATE     = 13'b0000000010000,
		ST_FF       = 13'b0000000100000,
		ST_DERR     = 13'b0000001000000,
		ST_PI_ACC   = 13'b0000010000000,
		ST_PI_CLAMP = 13'b0000100000000,
		ST_PI_SUM   = 13'b0001000000000,
		ST_PI_GAIN  = 13'b0010000000000,
		ST_PI_OUT   = 13'b0100000000000,
		ST_DONE     = 13'b1000000000000
	} state_t;

	cfg_t regs;

	spc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	state_t state_q;
	logic   rev_q;
	logic   loop_q;
	logic   out_valid_q;

	logic signed [INTEG_W-1:0] integ_s_q;
	logic signed [INTEG_W-1:0] integ_d_q;

	logic signed [ANG_W-1:0]   ang_q;
	logic signed [SPEED_W-1:0] tspd_q;
	logic signed [SPEED_W-1:0] mrate_q;
	logic signed [SPEED_W-1:0] mspd_q;
	logic signed [ERR_W-1:0]   err_s_q;
	logic signed [ERR_W-1:0]   err_d_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [DUTY_W-1:0]  scmd_q;
	logic signed [DUTY_W-1:0]  dcmd_q;

	logic signed [DUTY_W-1:0]  out_scmd_q;
	logic signed [DUTY_W-1:0]  out_dcmd_q;
	logic                      out_rev_q;

	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	spc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Loop select: 0 steer, 1 drive
	logic        [GAIN_W-1:0]  tau_sel;
	logic        [GAIN_W-1:0]  gain_sel;
	logic        [LIM_W-1:0]   lim_sel;
	logic signed [INTEG_W-1:0] integ_sel;
	logic signed [ERR_W-1:0]   err_sel;

	assign tau_sel   = loop_q ? regs.drive_time_const  : regs.steer_time_const;
	assign gain_sel  = loop_q ? regs.drive_output_gain : regs.steer_output_gain;
	assign lim_sel   = loop_q ? regs.drive_integ_limit : regs.steer_integ_limit;
	assign integ_sel = loop_q ? integ_d_q : integ_s_q;
	assign err_sel   = loop_q ? err_d_q   : err_s_q;

	logic                      accept;
	logic signed [ANG_W-1:0]   ang_start;
	logic                      ang_hi;
	logic                      ang_lo;
	logic signed [ANG_W-1:0]   ang_wrapped;
	logic signed [RATE_W-1:0]  rate_cmd;
	logic signed [ERR_W-1:0]   serr;
	logic signed [FF_W-1:0]    ff;
	logic signed [SPEED_W:0]   tspd_eff;
	logic signed [ERR_W-1:0]   derr;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   lim_pos;
	logic signed [INTEG_W-1:0] integ_new;
	logic signed [SUMF_W-1:0]  sum_full;
	logic signed [SUM_W-1:0]   sum_clamped;
	logic signed [DUTY_PRE_W-1:0] duty_q;
	logic signed [DUTY_PRE_W-1:0] duty_v;
	logic signed [DUTY_W-1:0]  duty_sat;

	assign accept = tick.valid && tick.ready;

	always_comb begin
		ang_start = ANG_W'(tick.target_angle) - ANG_W'(tick.measured_angle)
			+ (rev_q ? ANG_HALF : ANG_W'(0));
		ang_hi      = ang_q >= ANG_HALF;
		ang_lo      = ang_q < -ANG_HALF;
		ang_wrapped = ang_hi ? ang_q - ANG_FULL : ang_q + ANG_FULL;

		rate_cmd = $signed(mul_p[RATE_W+7:8]);
		serr     = ERR_W'(rate_cmd) - ERR_W'(mrate_q);

		ff       = $signed(mul_p[FF_W+7:8]);
		tspd_eff = rev_q ? -(($bits(tspd_eff))'(tspd_q)) : ($bits(tspd_eff))'(tspd_q);
		derr     = ERR_W'(tspd_eff) - ERR_W'(mspd_q) + ERR_W'(ff);

		acc     = ACC_W'(integ_sel) + (ACC_W'(err_sel) <<< INTEG_SHIFT);
		lim_pos = $signed({{(ACC_W-LIM_W){1'b0}}, lim_sel});
		if (acc_q > lim_pos) begin
			integ_new = INTEG_W'(lim_pos);
		end else if (acc_q < -lim_pos) begin
			integ_new = INTEG_W'(-lim_pos);
		end else begin
			integ_new = INTEG_W'(acc_q);
		end

		// Any sum of 2^24 or more saturates the duty for a nonzero Q8.8 gain
		sum_full = (SUMF_W'(mul_p) <<< 8) + SUMF_W'(integ_sel);
		if (sum_full > SUM_MAX) begin
			sum_clamped = SUM_W'(SUM_MAX);
		end else if (sum_full < -SUM_MAX) begin
			sum_clamped = SUM_W'(-SUM_MAX);
		end else begin
			sum_clamped = SUM_W'(sum_full);
		end

		duty_q = DUTY_PRE_W'($signed(mul_p[MUL_P_W-1:9]));
		duty_v = loop_q ? -duty_q : duty_q;
		if (duty_v > DUTY_MAX) begin
			duty_sat = DUTY_W'(DUTY_MAX);
		end else if (duty_v < DUTY_MIN) begin
			duty_sat = DUTY_W'(DUTY_MIN);
		end else begin
			duty_sat = DUTY_W'(duty_v);
		end
	end

	// Multiplier operand select
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_RATE: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(ang_q);
				mul_b  = $signed({1'b0, regs.steer_prop_gain});
			end
			ST_FF: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(rate_cmd);
				mul_b  = MUL_B_W'($signed(regs.turn_feedforward));
			end
			ST_PI_ACC: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(err_sel);
				mul_b  = $signed({1'b0, tau_sel});
			end
			ST_PI_GAIN: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(sum_q);
				mul_b  = $signed({1'b0, gain_sel});
			end
			default: ;
		endcase
	end

	assign tick.ready         = (state_q == ST_IDLE);
	assign duty.valid         = out_valid_q;
	assign duty.steer_command = out_scmd_q;
	assign duty.drive_command = out_dcmd_q;
	assign duty.reversed      = out_rev_q;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rev_q       <= 1'b0;
			loop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			integ_s_q   <= '0;
			integ_d_q   <= '0;
		end else begin
			if (duty.valid && duty.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WRAP1;
					end
				end
				ST_WRAP1: begin
					if (!ang_hi && !ang_lo) begin
						state_q <= ST_FLIP;
					end
				end
				ST_FLIP: begin
					if (ang_q > ANG_QUARTER || ang_q < -ANG_QUARTER) begin
						rev_q   <= !rev_q;
						state_q <= ST_WRAP2;
					end else begin
						state_q <= ST_RATE;
					end
				end
				ST_WRAP2: begin
					if (!ang_hi && !ang_lo) begin
						state_q <= ST_RATE;
					end
				end
				ST_RATE: state_q <= ST_FF;
				ST_FF:   state_q <= ST_DERR;
				ST_DERR: begin
					loop_q  <= 1'b0;
					state_q <= ST_PI_ACC;
				end
				ST_PI_ACC: state_q <= ST_PI_CLAMP;
				ST_PI_CLAMP: begin
					if (loop_q) begin
						integ_d_q <= integ_new;
					end else begin
						integ_s_q <= integ_new;
					end
					state_q <= ST_PI_SUM;
				end
				ST_PI_SUM:  state_q <= ST_PI_GAIN;
				ST_PI_GAIN: state_q <= ST_PI_OUT;
				ST_PI_OUT: begin
					if (loop_q) begin
						state_q <= ST_DONE;
					end else begin
						loop_q  <= 1'b1;
						state_q <= ST_PI_ACC;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || duty.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ang_q   <= ang_start;
					tspd_q  <= tick.target_speed;
					mrate_q <= tick.measured_steer_rate;
					mspd_q  <= tick.measured_speed;
				end
			end
			ST_WRAP1, ST_WRAP2: begin
				if (ang_hi || ang_lo) begin
					ang_q <= ang_wrapped;
				end
			end
			ST_FLIP: begin
				if (ang_q > ANG_QUARTER || ang_q < -ANG_QUARTER) begin
					ang_q <= ang_q + ANG_HALF;
				end
			end
			ST_FF:     err_s_q <= serr;
			ST_DERR:   err_d_q <= derr;
			ST_PI_ACC: acc_q   <= acc;
			ST_PI_SUM: sum_q   <= sum_clamped;
			ST_PI_OUT: begin
				if (loop_q) begin
					dcmd_q <= duty_sat;
				end else begin
					scmd_q <= duty_sat;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || duty.ready) begin
					out_scmd_q <= scmd_q;
					out_dcmd_q <= dcmd_q;
					out_rev_q  <= rev_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ tb/swerve_module_pi_control_unit_test.sv @@
`default_nettype none

module swerve_module_pi_control_unit_test;
	import spc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ANGLE_HALF    = 11520;
	localparam longint ANGLE_FULL    = 23040;
	localparam longint ANGLE_QUARTER = 5760;
	localparam longint SUM_CLAMP     = longint'(1) <<< 47;
	localparam int     HOLD_CYCLES   = 300;

	typedef struct {
		logic signed [ANGLE_W-1:0] target_angle;
		logic signed [SPEED_W-1:0] target_speed;
		logic signed [ANGLE_W-1:0] measured_angle;
		logic signed [SPEED_W-1:0] measured_steer_rate;
		logic signed [SPEED_W-1:0] measured_speed;
	} tick_beat_t;

	typedef struct {
		logic signed [DUTY_W-1:0] steer_command;
		logic signed [DUTY_W-1:0] drive_command;
		logic                     reversed;
	} duty_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spc_tick_if tick_ch ();
	spc_duty_if duty_ch ();
	spc_cfg_if  cfg_ch ();

	swerve_module_pi_control_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.duty   (duty_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// controller settings and state as the predictor sees them
	longint k_steer_prop, k_steer_out, k_steer_tau, k_steer_lim;
	longint k_drive_out, k_drive_tau, k_drive_lim, k_turn_ff;
	logic   rev_flag;
	longint steer_integ, drive_integ;

	tick_beat_t tick_q[$];
	duty_beat_t duty_expect_q[$];

	logic tick_fire = 1'b0;
	int   send_gap_pct = 0;
	int   ready_stall_pct = 0;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   hold_left = 0;
	int   fault_count = 0;

	function automatic longint clip(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// reduce modulo 360 degrees into [-180, 180)
	function automatic longint wrap_turn(longint e);
		longint r;
		r = e % ANGLE_FULL;
		if (r < 0)
			r += ANGLE_FULL;
		if (r >= ANGLE_HALF)
			r -= ANGLE_FULL;
		return r;
	endfunction

	function automatic longint velocity_pi(input longint err, inout longint integ,
			input longint limit, input longint tau, input longint gain);
		longint sum;
		integ = clip(integ + err * (longint'(1) <<< (16 - LOOP_TIME_SHIFT)), -limit, limit);
		sum = clip(err * tau * 256 + integ, -SUM_CLAMP, SUM_CLAMP);
		return (gain * sum) >>> 9;
	endfunction

	function automatic duty_beat_t control_tick(tick_beat_t t);
		longint perr, rate_cmd, serr, derr, spd, scmd, dcmd;
		duty_beat_t r;
		perr = longint'(t.target_angle) - longint'(t.measured_angle)
			+ (rev_flag ? ANGLE_HALF : 0);
		if (wrap_turn(perr) > ANGLE_QUARTER || wrap_turn(perr) < -ANGLE_QUARTER) begin
			rev_flag = ~rev_flag;
			perr += ANGLE_HALF;
		end
		perr = wrap_turn(perr);
		rate_cmd = (k_steer_prop * perr) >>> 8;
		serr = rate_cmd - longint'(t.measured_steer_rate);
		scmd = velocity_pi(serr, steer_integ, k_steer_lim, k_steer_tau, k_steer_out);
		spd = longint'(t.target_speed);
		if (rev_flag)
			spd = -spd;
		derr = spd - longint'(t.measured_speed) + ((k_turn_ff * rate_cmd) >>> 8);
		dcmd = velocity_pi(derr, drive_integ, k_drive_lim, k_drive_tau, k_drive_out);
		r.steer_command = DUTY_W'(clip(scmd, -32768, 32767));
		r.drive_command = DUTY_W'(clip(-dcmd, -32768, 32767));
		r.reversed = rev_flag;
		return r;
	endfunction

	function automatic tick_beat_t make_tick(int ta, int ts, int ma, int mr, int ms);
		tick_beat_t t;
		t.target_angle = ANGLE_W'(ta);
		t.target_speed = SPEED_W'(ts);
		t.measured_angle = ANGLE_W'(ma);
		t.measured_steer_rate = SPEED_W'(mr);
		t.measured_speed = SPEED_W'(ms);
		return t;
	endfunction

	// mostly realistic ticks: measured angle near target, moderate speeds
	function automatic tick_beat_t random_tick();
		tick_beat_t t;
		if ($urandom_range(9) < 2)
			t.target_angle = ANGLE_W'($urandom);
		else
			t.target_angle = ANGLE_W'(int'($urandom_range(23040)) - 11520);
		if ($urandom_range(9) < 3)
			t.measured_angle = ANGLE_W'($urandom);
		else
			t.measured_angle = ANGLE_W'(int'(t.target_angle) + int'($urandom_range(14000)) - 7000);
		t.target_speed = ($urandom_range(9) < 3) ? SPEED_W'($urandom)
			: SPEED_W'(int'($urandom_range(4000)) - 2000);
		t.measured_steer_rate = ($urandom_range(9) < 3) ? SPEED_W'($urandom)
			: SPEED_W'(int'($urandom_range(4000)) - 2000);
		t.measured_speed = ($urandom_range(9) < 3) ? SPEED_W'($urandom)
			: SPEED_W'(int'($urandom_range(4000)) - 2000);
		return t;
	endfunction

	// small gains most of the time (turn feedforward always random) so that duties stay off the rails
	function automatic cfg_t random_settings();
		cfg_t c;
		logic wide;
		wide = ($urandom_range(3) == 0);
		c.steer_prop_gain = wide ? GAIN_W'($urandom) : GAIN_W'($urandom_range(512));
		c.steer_output_gain = wide ? GAIN_W'($urandom) : GAIN_W'($urandom_range(6));
		c.steer_time_const = wide ? GAIN_W'($urandom) : GAIN_W'($urandom_range(4));
		c.steer_integ_limit = wide ? LIM_W'($urandom) : LIM_W'($urandom_range(1 << 22));
		c.drive_output_gain = wide ? GAIN_W'($urandom) : GAIN_W'($urandom_range(6));
		c.drive_time_const = wide ? GAIN_W'($urandom) : GAIN_W'($urandom_range(4));
		c.drive_integ_limit = wide ? LIM_W'($urandom) : LIM_W'($urandom_range(1 << 22));
		c.turn_feedforward = GAIN_W'($urandom);
		return c;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic load_settings(cfg_t c);
		write_reg(REG_STEER_PROP_GAIN, CFG_DATA_W'(c.steer_prop_gain));
		write_reg(REG_STEER_OUTPUT_GAIN, CFG_DATA_W'(c.steer_output_gain));
		write_reg(REG_STEER_TIME_CONST, CFG_DATA_W'(c.steer_time_const));
		write_reg(REG_STEER_INTEG_LIMIT, CFG_DATA_W'(c.steer_integ_limit));
		write_reg(REG_DRIVE_OUTPUT_GAIN, CFG_DATA_W'(c.drive_output_gain));
		write_reg(REG_DRIVE_TIME_CONST, CFG_DATA_W'(c.drive_time_const));
		write_reg(REG_DRIVE_INTEG_LIMIT, CFG_DATA_W'(c.drive_integ_limit));
		write_reg(REG_TURN_FEEDFORWARD, CFG_DATA_W'(c.turn_feedforward));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (tick_q.size() != 0 || tick_ch.valid || duty_expect_q.size() != 0);
	endtask

	// tick driver
	always @(negedge clk) begin : drive_ticks
		tick_beat_t nxt;
		if (!tick_ch.valid || tick_fire) begin
			if (tick_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nxt = tick_q.pop_front();
				tick_ch.valid <= 1'b1;
				tick_ch.target_angle <= nxt.target_angle;
				tick_ch.target_speed <= nxt.target_speed;
				tick_ch.measured_angle <= nxt.measured_angle;
				tick_ch.measured_steer_rate <= nxt.measured_steer_rate;
				tick_ch.measured_speed <= nxt.measured_speed;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// duty backpressure, with a long hold-off on request
	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left <= HOLD_CYCLES;
			duty_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			duty_ch.ready <= 1'b0;
		end else begin
			duty_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// beat monitor: settings, predictions, duty checks
	always @(posedge clk) begin : watch_beats
		tick_beat_t seen;
		duty_beat_t want;
		tick_fire <= arst_n && tick_ch.valid && tick_ch.ready;
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_idx_t'(cfg_ch.index))
				REG_STEER_PROP_GAIN:   k_steer_prop = longint'(cfg_ch.data[GAIN_W-1:0]);
				REG_STEER_OUTPUT_GAIN: k_steer_out = longint'(cfg_ch.data[GAIN_W-1:0]);
				REG_STEER_TIME_CONST:  k_steer_tau = longint'(cfg_ch.data[GAIN_W-1:0]);
				REG_STEER_INTEG_LIMIT: k_steer_lim = longint'(cfg_ch.data[LIM_W-1:0]);
				REG_DRIVE_OUTPUT_GAIN: k_drive_out = longint'(cfg_ch.data[GAIN_W-1:0]);
				REG_DRIVE_TIME_CONST:  k_drive_tau = longint'(cfg_ch.data[GAIN_W-1:0]);
				REG_DRIVE_INTEG_LIMIT: k_drive_lim = longint'(cfg_ch.data[LIM_W-1:0]);
				REG_TURN_FEEDFORWARD:  k_turn_ff = longint'($signed(cfg_ch.data[GAIN_W-1:0]));
				default: ;
			endcase
		end
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			seen.target_angle = tick_ch.target_angle;
			seen.target_speed = tick_ch.target_speed;
			seen.measured_angle = tick_ch.measured_angle;
			seen.measured_steer_rate = tick_ch.measured_steer_rate;
			seen.measured_speed = tick_ch.measured_speed;
			duty_expect_q.push_back(control_tick(seen));
		end
		if (arst_n && duty_ch.valid && duty_ch.ready) begin
			if (duty_expect_q.size() == 0) begin
				$error("duty beat with no tick pending: steer %0d drive %0d reversed %0b",
					duty_ch.steer_command, duty_ch.drive_command, duty_ch.reversed);
				fault_count++;
			end else begin
				want = duty_expect_q.pop_front();
				if (duty_ch.steer_command !== want.steer_command) begin
					$error("steer_command: expected %0d, got %0d",
						want.steer_command, duty_ch.steer_command);
					fault_count++;
				end
				if (duty_ch.drive_command !== want.drive_command) begin
					$error("drive_command: expected %0d, got %0d",
						want.drive_command, duty_ch.drive_command);
					fault_count++;
				end
				if (duty_ch.reversed !== want.reversed) begin
					$error("reversed: expected %0b, got %0b", want.reversed, duty_ch.reversed);
					fault_count++;
				end
			end
		end
	end

	initial begin : run
		cfg_t s;
		tick_ch.valid = 1'b0;
		tick_ch.target_angle = '0;
		tick_ch.target_speed = '0;
		tick_ch.measured_angle = '0;
		tick_ch.measured_steer_rate = '0;
		tick_ch.measured_speed = '0;
		duty_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_STEER_PROP_GAIN;
		cfg_ch.data = '0;
		k_steer_prop = 0; k_steer_out = 0; k_steer_tau = 0; k_steer_lim = 0;
		k_drive_out = 0; k_drive_tau = 0; k_drive_lim = 0; k_turn_ff = 0;
		rev_flag = 1'b0;
		steer_integ = 0;
		drive_integ = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unity-ish gains so duties stay readable
		s.steer_prop_gain = 16'h0100;
		s.steer_output_gain = 16'd1;
		s.steer_time_const = 16'd1;
		s.steer_integ_limit = 31'h0001_0000;
		s.drive_output_gain = 16'd1;
		s.drive_time_const = 16'd2;
		s.drive_integ_limit = 31'h0004_0000;
		s.turn_feedforward = 16'h0080;
		load_settings(s);

		tick_q.push_back(make_tick(0, 0, 0, 0, 0));
		tick_q.push_back(make_tick(5760, 100, 0, 0, 50));      // exactly +90: stays forward
		tick_q.push_back(make_tick(5761, 100, 0, 0, 50));      // just past 90: flips
		tick_q.push_back(make_tick(0, 300, 0, 20, -40));       // flip back through 180
		tick_q.push_back(make_tick(-5760, -200, 0, 0, 0));     // exactly -90
		tick_q.push_back(make_tick(-5761, -200, 0, -10, 0));
		tick_q.push_back(make_tick(11520, 500, -11520, 0, 0));
		tick_q.push_back(make_tick(-16384, 0, 16383, 0, 0));   // beyond +-180
		tick_q.push_back(make_tick(16383, 0, -16384, 0, 0));
		tick_q.push_back(make_tick(11520, 0, 11520, 0, 0));
		tick_q.push_back(make_tick(0, 32767, 0, 0, -32768));
		tick_q.push_back(make_tick(0, -32768, 0, 0, 32767));
		tick_q.push_back(make_tick(200, 0, 0, 32767, 0));
		tick_q.push_back(make_tick(-200, 0, 0, -32768, 0));
		tick_q.push_back(make_tick(16383, 32767, 16383, 32767, 32767));
		tick_q.push_back(make_tick(-16384, -32768, -16384, -32768, -32768));
		settle();

		// everything at the top: sum clamp and duty saturation
		s.steer_prop_gain = 16'hFFFF;
		s.steer_output_gain = 16'hFFFF;
		s.steer_time_const = 16'hFFFF;
		s.steer_integ_limit = 31'h7FFF_FFFF;
		s.drive_output_gain = 16'hFFFF;
		s.drive_time_const = 16'hFFFF;
		s.drive_integ_limit = 31'h7FFF_FFFF;
		s.turn_feedforward = 16'h7FFF;
		load_settings(s);
		tick_q.push_back(make_tick(11520, 32767, -11520, -32768, -32768));
		tick_q.push_back(make_tick(-16384, -32768, 16383, 32767, 32767));
		tick_q.push_back(make_tick(3000, 1000, 0, 0, 0));
		tick_q.push_back(make_tick(0, 0, 0, 0, 0));
		repeat (60) tick_q.push_back(random_tick());
		send_gap_pct = 49;
		settle();

		// everything at the bottom: zero integrator limits, most negative feedforward
		s.steer_prop_gain = '0;
		s.steer_output_gain = '0;
		s.steer_time_const = '0;
		s.steer_integ_limit = '0;
		s.drive_output_gain = '0;
		s.drive_time_const = '0;
		s.drive_integ_limit = '0;
		s.turn_feedforward = 16'h8000;
		load_settings(s);
		send_gap_pct = 0;
		ready_stall_pct = 49;
		repeat (50) tick_q.push_back(random_tick());
		settle();

		load_settings(random_settings());
		ready_stall_pct = 0;
		repeat (110) tick_q.push_back(random_tick());
		settle();

		load_settings(random_settings());
		send_gap_pct = 37;
		ready_stall_pct = 37;
		repeat (110) tick_q.push_back(random_tick());
		settle();

		load_settings(random_settings());
		send_gap_pct = 0;
		ready_stall_pct = 0;
		holds_asked++;
		repeat (110) tick_q.push_back(random_tick());
		settle();

		repeat (40) @(posedge clk);
		if (duty_expect_q.size() != 0) begin
			$error("%0d duty beats never arrived", duty_expect_q.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/spc_pkg.sv
hw/rtl/spc_if.sv
hw/rtl/spc_cfg_regs.sv
hw/rtl/spc_mul.sv
hw/rtl/swerve_module_pi_control_unit.sv
tb/swerve_module_pi_control_unit_test.sv
